>>> rtl/assert_macros.svh
// Shared assertion macros; the enclosing module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SPCS_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spcs property violated");

// Condition seen now implies the outcome on the next edge.
`define SPCS_ASSERT_NEXT(name, cond, outcome) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (outcome)) \
        else $error("spcs next-cycle property violated");

`endif

>>> rtl/spcs_pkg.sv
package spcs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_CLASSES = 4;

    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int ID_W      = 16;
    localparam int DUR_W     = 16;
    localparam int CLASS_W   = 2;
    localparam int TICK_W    = 32;
    localparam int KIND_W    = 2;
    localparam int WORD_W    = ID_W + DUR_W;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [KIND_W-1:0] KIND_LOGGED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_READ = 3'b100
    } state_t;

    // Queue pointer bank commands from the sequencer
    typedef struct packed {
        logic               push;
        logic               pop;
        logic [CLASS_W-1:0] cls;
    } qptr_cmd_t;

    // Queue pointer bank status back to the sequencer
    typedef struct packed {
        logic              full;
        logic              any;
        logic [CLS_W-1:0]  pick_cls;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
    } qptr_stat_t;

endpackage

>>> rtl/spcs_ram.sv
module spcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

>>> rtl/spcs_qptr.sv
module spcs_qptr
    import spcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qptr_cmd_t  cmd,
    output qptr_stat_t stat
);

    logic [PTR_W-1:0] head_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] head_next [NUM_CLASSES];
    logic [PTR_W-1:0] tail_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] tail_next [NUM_CLASSES];
    logic [CNT_W-1:0] count_reg [NUM_CLASSES];
    logic [CNT_W-1:0] count_next[NUM_CLASSES];

    logic [CLS_W-1:0] cls_idx;
    logic             cls_ok;
    logic             any;
    logic [CLS_W-1:0] pick;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(int'(p) + 1);
    endfunction

    assign cls_idx = CLS_W'(cmd.cls);
    assign cls_ok  = (int'(cmd.cls) < NUM_CLASSES);

    // Highest non-empty class wins
    always_comb
    begin
        any  = 1'b0;
        pick = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (count_reg[c] != '0)
            begin
                any  = 1'b1;
                pick = CLS_W'(c);
            end
        end
    end

    always_comb
    begin
        stat.full     = !cls_ok || (count_reg[cls_idx] == CNT_W'(QUEUE_DEPTH));
        stat.any      = any;
        stat.pick_cls = pick;
        stat.wr_addr  = ADDR_W'(int'(cls_idx) * QUEUE_DEPTH + int'(tail_reg[cls_idx]));
        stat.rd_addr  = ADDR_W'(int'(pick) * QUEUE_DEPTH + int'(head_reg[pick]));
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            tail_next[cls_idx]  = next_slot(tail_reg[cls_idx]);
            count_next[cls_idx] = count_reg[cls_idx] + 1'b1;
        end
        if (cmd.pop)
        begin
            head_next[pick]  = next_slot(head_reg[pick]);
            count_next[pick] = count_reg[pick] - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c]  <= '0;
                tail_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/strict_priority_call_scheduler_core.sv
// Strict-priority call scheduler: one FIFO per class in a shared queue RAM and a single
// non-preemptive server. A request with tuser 0 is an arrival (logged, or dropped when its
// class queue is full); tuser 1 ends a tick (finish the call that is due, start the oldest
// call of the highest non-empty class, advance counters). Each request yields at most one
// result, stamped with the tick count before that tick advances. One request is worked at
// a time: an arrival or a tick with nothing to dequeue is finished in ST_EXEC, while a
// tick that dequeues goes on to ST_READ since the queue RAM read is registered. While the
// result register still holds a result that the sink has not taken, the request in progress
// waits in place, whether or not it produces a result of its own. Queue fill counts guard
// every read, so the RAM needs no clearing pass after reset.
module strict_priority_call_scheduler_core
    import spcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] caller_id, [17:16] member_class, [33:18] call_duration, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] operation
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] out_caller_id, [17:16] out_class, [49:18] tick_number, rest zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [1:0] result_kind
    output logic [KIND_W-1:0]    m_tuser
);

    state_t               state_reg, state_next;
    logic                 op_reg, op_next;
    logic [ID_W-1:0]      caller_reg, caller_next;
    logic [CLASS_W-1:0]   cls_reg, cls_next;
    logic [DUR_W-1:0]     dur_reg, dur_next;
    logic [DUR_W-1:0]     elapsed_reg, elapsed_next;
    logic [DUR_W-1:0]     needed_reg, needed_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [CLS_W-1:0]     start_cls_reg, start_cls_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [KIND_W-1:0]    out_kind_reg, out_kind_next;

    qptr_cmd_t            qcmd;
    qptr_stat_t           qstat;
    logic                 ram_we;
    logic                 ram_re;
    logic [WORD_W-1:0]    ram_rdata;

    logic                 out_free;
    logic                 emit;
    logic [KIND_W-1:0]    emit_kind;
    logic [ID_W-1:0]      emit_id;
    logic [CLASS_W-1:0]   emit_cls;

    spcs_qptr u_qptr (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (qcmd),
        .stat  (qstat)
    );

    spcs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (qstat.wr_addr),
        .wdata ({dur_reg, caller_reg}),
        .re    (ram_re),
        .raddr (qstat.rd_addr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        caller_next    = caller_reg;
        cls_next       = cls_reg;
        dur_next       = dur_reg;
        elapsed_next   = elapsed_reg;
        needed_next    = needed_reg;
        tick_next      = tick_reg;
        start_cls_next = start_cls_reg;
        qcmd.push      = 1'b0;
        qcmd.pop       = 1'b0;
        qcmd.cls       = cls_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        emit           = 1'b0;
        emit_kind      = KIND_LOGGED;
        emit_id        = caller_reg;
        emit_cls       = cls_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    caller_next = s_tdata[ID_W-1:0];
                    cls_next    = s_tdata[ID_W+CLASS_W-1:ID_W];
                    dur_next    = s_tdata[ID_W+CLASS_W+DUR_W-1:ID_W+CLASS_W];
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register can take a new result
                if (out_free)
                begin
                    if (op_reg == OP_ARRIVAL)
                    begin
                        emit = 1'b1;
                        if (qstat.full)
                        begin
                            emit_kind = KIND_DROPPED;
                        end
                        else
                        begin
                            emit_kind = KIND_LOGGED;
                            ram_we    = 1'b1;
                            qcmd.push = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                    else if ((elapsed_reg == needed_reg) && qstat.any)
                    begin
                        // current call done: fetch the next one from the queue RAM
                        ram_re         = 1'b1;
                        qcmd.pop       = 1'b1;
                        start_cls_next = qstat.pick_cls;
                        state_next     = ST_READ;
                    end
                    else
                    begin
                        if (elapsed_reg < needed_reg)
                        begin
                            elapsed_next = elapsed_reg + 1'b1;
                        end
                        tick_next  = tick_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    needed_next = ram_rdata[WORD_W-1:ID_W];
                    if (ram_rdata[WORD_W-1:ID_W] != '0)
                    begin
                        emit         = 1'b1;
                        emit_kind    = KIND_START;
                        emit_id      = ram_rdata[ID_W-1:0];
                        emit_cls     = CLASS_W'(start_cls_reg);
                        elapsed_next = DUR_W'(1);
                    end
                    else
                    begin
                        // zero-length call occupies the server for this tick only
                        elapsed_next = '0;
                    end
                    tick_next  = tick_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            out_data_next  = {(M_TDATA_W - ID_W - CLASS_W - TICK_W)'(0),
                              tick_reg, emit_cls, emit_id};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            elapsed_reg   <= '0;
            needed_reg    <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            needed_reg    <= needed_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        caller_reg    <= caller_next;
        cls_reg       <= cls_next;
        dur_reg       <= dur_next;
        start_cls_reg <= start_cls_next;
        out_data_reg  <= out_data_next;
        out_kind_reg  <= out_kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

>>> rtl/spcs_checker.sv
`include "assert_macros.svh"

module spcs_checker
    import spcs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]    m_tuser
);

    // a stalled result holds its payload
    `SPCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))

    // one request at a time: taking a request makes the block busy
    `SPCS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // a busy block cannot finish while its result register is blocked
    `SPCS_ASSERT_NEXT(a_stall_keeps_busy, m_tvalid && !m_tready && !s_tready, !s_tready)

    // a fresh result is only produced while a request is in progress
    `SPCS_ASSERT(a_result_from_request, $rose(m_tvalid) |-> !$past(s_tready))

endmodule

bind strict_priority_call_scheduler_core spcs_checker u_spcs_checker (.*);

>>> dv/strict_priority_call_scheduler_core_test.sv
`timescale 1ns / 100ps

module strict_priority_call_scheduler_core_test;
    import spcs_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_PRINTS  = 50;

    typedef struct {
        logic             op;
        logic [ID_W-1:0]  id;
        logic [1:0]       cls;
        logic [DUR_W-1:0] dur;
        int               gap;
        bit               drain;
    } call_req_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [1:0]        cls;
        logic [TICK_W-1:0] tick;
    } call_result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;

    strict_priority_call_scheduler_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    call_req_t    pending_calls[$];
    call_result_t expected_results[$];
    call_req_t    tx_item;
    int           tx_gap;
    int           gap_max;
    bit           hold_for_drain;
    int           n_queued;
    int           n_results;
    int           n_errors;
    int           rx_stall;
    int           rx_hold;
    int           idle_cycles;

    // Scheduler state as seen by the predictor
    logic [WORD_W-1:0] line_word[NUM_CLASSES][QUEUE_DEPTH];
    int                line_head[NUM_CLASSES];
    int                line_tail[NUM_CLASSES];
    int                line_fill[NUM_CLASSES];
    logic [DUR_W-1:0]  svc_elapsed;
    logic [DUR_W-1:0]  svc_needed;
    logic [ID_W-1:0]   svc_caller;
    logic [TICK_W-1:0] tick_cnt;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        // keep the log short when the block is badly off
        if (n_errors <= MAX_PRINTS)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    task automatic push_result(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id, logic [1:0] cls);
        call_result_t res;
        res.kind = kind;
        res.id   = id;
        res.cls  = cls;
        res.tick = tick_cnt;
        expected_results.push_back(res);
    endtask

    task automatic schedule_call(call_req_t r);
        int          c;
        int          start_cls;
        logic [WORD_W-1:0] word;
        c = int'(r.cls);
        start_cls = 0;
        if (r.op == OP_ARRIVAL)
        begin
            if (c >= NUM_CLASSES || line_fill[c] >= QUEUE_DEPTH)
            begin
                push_result(KIND_DROPPED, r.id, r.cls);
            end
            else
            begin
                line_word[c][line_tail[c]] = {r.dur, r.id};
                line_tail[c] = (line_tail[c] + 1) % QUEUE_DEPTH;
                line_fill[c]++;
                push_result(KIND_LOGGED, r.id, r.cls);
            end
        end
        else
        begin
            // finish the current call, then take the highest class waiting
            if (svc_elapsed == svc_needed)
            begin
                for (int k = NUM_CLASSES - 1; k >= 0; k--)
                begin
                    if (line_fill[k] > 0)
                    begin
                        word = line_word[k][line_head[k]];
                        line_head[k] = (line_head[k] + 1) % QUEUE_DEPTH;
                        line_fill[k]--;
                        svc_caller  = word[ID_W-1:0];
                        svc_needed  = word[WORD_W-1:ID_W];
                        svc_elapsed = '0;
                        start_cls   = k;
                        break;
                    end
                end
            end
            if (svc_elapsed < svc_needed)
            begin
                if (svc_elapsed == '0)
                    push_result(KIND_START, svc_caller, 2'(start_cls));
                svc_elapsed = svc_elapsed + 1'b1;
            end
            tick_cnt = tick_cnt + 1'b1;
        end
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        call_req_t nxt;
        logic      load;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            load = 1'b0;
            if (s_tvalid && s_tready)
                schedule_call(tx_item);
            if (!s_tvalid || s_tready)
            begin
                if (pending_calls.size() > 0 &&
                    !(pending_calls[0].drain && expected_results.size() > 0))
                begin
                    if (tx_gap < pending_calls[0].gap)
                    begin
                        tx_gap++;
                    end
                    else
                    begin
                        nxt = pending_calls.pop_front();
                        tx_gap = 0;
                        load = 1'b1;
                    end
                end
                s_tvalid <= load;
                if (load)
                begin
                    tx_item = nxt;
                    s_tdata <= S_TDATA_W'({nxt.dur, nxt.cls, nxt.id});
                    s_tuser <= nxt.op;
                end
            end
        end
    end

    // Monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        call_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall = 0;
            rx_hold  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", m_tdata[31:0], '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch("result_kind", 32'(m_tuser), 32'(want.kind));
                    if (m_tdata[15:0] !== want.id)
                        report_mismatch("out_caller_id", 32'(m_tdata[15:0]), 32'(want.id));
                    if (m_tdata[17:16] !== want.cls)
                        report_mismatch("out_class", 32'(m_tdata[17:16]), 32'(want.cls));
                    if (m_tdata[49:18] !== want.tick)
                        report_mismatch("tick_number", m_tdata[49:18], want.tick);
                end
                rx_stall = ((n_results / 50) % 3 == 2) ? 0 : $urandom_range(0, 4);
                // back up the block once while requests keep coming
                if (n_results == 150)
                    rx_hold = LONG_HOLD;
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
            end
            m_tready <= (rx_hold == 0 && rx_stall == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic add_call(logic op, logic [ID_W-1:0] id, logic [1:0] cls, logic [DUR_W-1:0] dur);
        call_req_t r;
        r.op    = op;
        r.id    = id;
        r.cls   = cls;
        r.dur   = dur;
        r.gap   = $urandom_range(0, gap_max);
        r.drain = hold_for_drain;
        hold_for_drain = 1'b0;
        pending_calls.push_back(r);
        n_queued++;
    endtask

    function automatic logic [DUR_W-1:0] rand_dur();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return DUR_W'($urandom_range(0, 3));
        else if (pick < 19)
            return DUR_W'($urandom_range(4, 12));
        else
            return DUR_W'($urandom_range(13, 60));
    endfunction

    task automatic add_arrival(logic [1:0] cls);
        add_call(OP_ARRIVAL, 16'($urandom), cls, rand_dur());
    endtask

    // tick fields are don't-care; fill them with noise
    task automatic add_tick();
        add_call(OP_TICK, 16'($urandom), 2'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int seq;
        int cnt;
        int cls;
        n_queued = 0;
        n_results = 0;
        n_errors = 0;
        idle_cycles = 0;
        gap_max = 4;
        hold_for_drain = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            line_head[c] = 0;
            line_tail[c] = 0;
            line_fill[c] = 0;
        end
        svc_elapsed = '0;
        svc_needed  = '0;
        svc_caller  = '0;
        tick_cnt    = '0;

        // Directed: idle tick, field extremes, zero duration, priority order
        add_tick();
        add_call(OP_ARRIVAL, 16'h0000, 2'd0, 16'd1);
        add_call(OP_ARRIVAL, 16'hFFFF, 2'd3, 16'd2);
        add_call(OP_ARRIVAL, 16'h1234, 2'd1, 16'd0);
        add_call(OP_ARRIVAL, 16'hABCD, 2'd2, 16'd3);
        add_call(OP_ARRIVAL, 16'h5555, 2'd3, 16'd0);
        for (int i = 0; i < 12; i++)
            add_tick();
        add_call(OP_ARRIVAL, 16'hAAAA, 2'd2, 16'd1);
        add_tick();
        add_tick();

        // Random sequences
        hold_for_drain = 1'b1;
        while (n_queued < 600)
        begin
            gap_max = ((n_queued / 150) % 2 == 0) ? 4 : 0;
            seq = $urandom_range(0, 9);
            if (seq == 0)
            begin
                // overflow one class queue
                cls = $urandom_range(0, NUM_CLASSES - 1);
                cnt = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 3);
                for (int i = 0; i < cnt; i++)
                    add_arrival(2'(cls));
                cnt = $urandom_range(10, 30);
                for (int i = 0; i < cnt; i++)
                    add_tick();
            end
            else if (seq <= 6)
            begin
                cnt = $urandom_range(1, 6);
                for (int i = 0; i < cnt; i++)
                    add_arrival(2'($urandom_range(0, 3)));
                cnt = $urandom_range(1, 8);
                for (int i = 0; i < cnt; i++)
                    add_tick();
            end
            else if (seq <= 8)
            begin
                cnt = $urandom_range(1, 10);
                for (int i = 0; i < cnt; i++)
                begin
                    if ($urandom_range(0, 1))
                        add_tick();
                    else
                        add_arrival(2'($urandom_range(0, 3)));
                end
            end
            else
            begin
                hold_for_drain = 1'b1;
            end
        end

        // Longest durations last, so they cannot starve the rest of the run
        hold_for_drain = 1'b1;
        add_call(OP_ARRIVAL, 16'($urandom), 2'd3, 16'hFFFF);
        add_call(OP_ARRIVAL, 16'($urandom), 2'd3, 16'h8000);
        for (int i = 0; i < 4; i++)
            add_tick();

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_calls.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        while (expected_results.size() > 0)
        begin
            call_result_t left;
            left = expected_results.pop_front();
            report_mismatch("missing result for caller", 32'(left.id), 32'(left.kind));
        end
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
